// ===== design/assert_macros.svh =====
// Shared assertion macros for the edge builder checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define EGB_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("edge builder check failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define EGB_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("edge builder check failed: next-cycle implication");

`endif

// ===== design/egb_pkg.sv =====
package egb_pkg;

    localparam int CHANNEL_COUNT = 64;
    localparam int CH_W          = 6;
    localparam int MAX_RADIUS    = 30;
    localparam int NUM_W         = 50;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = 2;

    localparam logic [13:0] FILTER_BASE  = 14'd1000;
    localparam logic [13:0] FILTER_SLOPE = 14'd100;
    localparam logic [31:0] MIN_AGE      = 32'd2000;

    typedef struct packed {
        logic [31:0] event_time;
        logic [5:0]  event_channel;
        logic        event_polarity;
    } in_item_t;

    typedef struct packed {
        logic        record_kind;
        logic [31:0] node_index;
        logic [31:0] neighbor_index;
        logic [31:0] node_time;
        logic [5:0]  node_channel;
        logic [31:0] feature_time;
        logic [31:0] feature_channel;
        logic        polarity_out;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [4:0]  radius;
        logic [5:0]  stride;
        logic [31:0] age_limit;
        logic [31:0] norm_window;
        logic        feature_mode;
        logic        pol_enable;
    } cfg_t;

    typedef enum logic [2:0] {
        REG_CHANNEL_RADIUS = 3'd0,
        REG_SKIP_CHANNELS  = 3'd1,
        REG_AGE_LIMIT      = 3'd2,
        REG_NORM_WINDOW    = 3'd3,
        REG_FEATURE_MODE   = 3'd4,
        REG_POL_ENABLE     = 3'd5
    } reg_idx_t;

    typedef enum logic {
        F_IDLE,
        F_EVAL
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SELF,
        B_SCAN,
        B_CHK,
        B_MT,
        B_MTW,
        B_MC,
        B_MCW,
        B_FT,
        B_FTW,
        B_FC,
        B_FCW,
        B_NODE
    } back_state_t;

endpackage

// ===== design/egb_fifo.sv =====
module egb_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  egb_pkg::in_item_t wdata,
    input  logic              pop,
    output egb_pkg::in_item_t rdata,
    output logic              full,
    output logic              empty
);

    egb_pkg::in_item_t                mem [egb_pkg::QDEPTH];
    logic [egb_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [egb_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [egb_pkg::QPTR_W:0]         count_reg, count_next;

    assign full  = (count_reg == (egb_pkg::QPTR_W+1)'(egb_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (egb_pkg::QPTR_W)'(push);
        rd_ptr_next = rd_ptr_reg + (egb_pkg::QPTR_W)'(pop);
        count_next  = count_reg + (egb_pkg::QPTR_W+1)'(push) - (egb_pkg::QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== design/egb_front.sv =====
module egb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  egb_pkg::in_item_t in_data,
    input  logic              q_full,
    output logic              q_push,
    output egb_pkg::in_item_t q_data
);

    egb_pkg::front_state_t state_reg, state_next;
    egb_pkg::in_item_t     item_reg;
    logic [33:0]           filt_mem [egb_pkg::CHANNEL_COUNT];
    logic [33:0]           filt_q;
    logic [63:0]           fvalid_reg, fvalid_next;
    logic                  accept;
    logic                  wr_en;
    logic [31:0]           prev_t, dt;
    logic [1:0]            prev_l, new_l;
    logic                  fire;
    logic [13:0]           period;
    logic [14:0]           period2;
    logic [5:0]            ch;

    assign ch       = item_reg.event_channel;
    assign in_ready = (state_reg == egb_pkg::F_IDLE) && !q_full;
    assign accept   = in_valid && in_ready;
    assign q_data   = item_reg;

    // Evaluate leaky counter against one or two decay periods
    always_comb
    begin
        prev_t  = fvalid_reg[ch] ? filt_q[33:2] : 32'd0;
        prev_l  = fvalid_reg[ch] ? filt_q[1:0] : 2'd0;
        dt      = (item_reg.event_time >= prev_t) ? item_reg.event_time - prev_t : 32'd0;
        period  = egb_pkg::FILTER_BASE + egb_pkg::FILTER_SLOPE * {8'd0, ch};
        period2 = {period, 1'b0};
        fire    = 1'b0;
        new_l   = 2'd1;
        case (prev_l)
            2'd1:
            begin
                new_l = (dt >= {18'd0, period}) ? 2'd1 : 2'd2;
            end
            2'd2:
            begin
                if (dt >= {17'd0, period2})
                begin
                    new_l = 2'd1;
                end
                else if (dt >= {18'd0, period})
                begin
                    new_l = 2'd2;
                end
                else
                begin
                    fire  = 1'b1;
                    new_l = 2'd0;
                end
            end
            default:
            begin
                new_l = 2'd1;
            end
        endcase
    end

    // Sequence accept and evaluate
    always_comb
    begin
        state_next  = state_reg;
        wr_en       = 1'b0;
        q_push      = 1'b0;
        fvalid_next = fvalid_reg;
        unique case (state_reg)
            egb_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    state_next = egb_pkg::F_EVAL;
                end
            end
            egb_pkg::F_EVAL:
            begin
                wr_en           = 1'b1;
                q_push          = fire;
                fvalid_next[ch] = 1'b1;
                state_next      = egb_pkg::F_IDLE;
            end
            default:
            begin
                state_next = egb_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= egb_pkg::F_IDLE;
            fvalid_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fvalid_reg <= fvalid_next;
        end
    end

    // Capture item and read filter entry
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
            filt_q   <= filt_mem[in_data.event_channel];
        end
        if (wr_en)
        begin
            filt_mem[ch] <= {item_reg.event_time, new_l};
        end
    end

endmodule

// ===== design/egb_div.sv =====
module egb_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [egb_pkg::NUM_W-1:0] num,
    input  logic [31:0]               den,
    output logic                      done,
    output logic [egb_pkg::NUM_W-1:0] quo
);

    logic [31:0]               rem_reg, rem_next;
    logic [egb_pkg::NUM_W-1:0] quo_reg, quo_next;
    logic [31:0]               den_reg;
    logic [5:0]                cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [32:0]               trial;
    logic                      qbit;

    assign done = done_reg;
    assign quo  = quo_reg;

    // Shift in one numerator bit and subtract when it fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[egb_pkg::NUM_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = 6'(egb_pkg::NUM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            quo_next = {quo_reg[egb_pkg::NUM_W-2:0], qbit};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

endmodule

// ===== design/egb_back.sv =====
module egb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  egb_pkg::cfg_t      cfg,
    input  logic               q_empty,
    input  egb_pkg::in_item_t  q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output egb_pkg::out_item_t out_data
);

    egb_pkg::back_state_t state_reg, state_next;
    egb_pkg::in_item_t    item_reg, item_next;
    egb_pkg::out_item_t   out_reg, out_next;
    logic                 out_valid_reg;
    logic                 load;
    logic                 ofree;

    logic [31:0] rt_mem [egb_pkg::CHANNEL_COUNT];
    logic [31:0] rn_mem [egb_pkg::CHANNEL_COUNT];
    logic [31:0] rt_q, rn_q;
    logic [63:0] rvalid_reg, rvalid_next;
    logic        rd_en, wr_en;

    logic [31:0]        node_cnt_reg, node_cnt_next;
    logic signed [8:0]  n_reg, n_next;
    logic signed [8:0]  n_hi;
    logic [37:0]        sum_t_reg, sum_t_next;
    logic signed [12:0] sum_c_reg, sum_c_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [32:0]        mean_t_reg, mean_t_next;
    logic [11:0]        mean_c_reg, mean_c_next;
    logic               neg_c_reg, neg_c_next;
    logic [31:0]        ft_reg, ft_next, fc_reg, fc_next;

    logic                      div_start;
    logic [egb_pkg::NUM_W-1:0] div_num;
    logic [31:0]               div_den;
    logic                      div_done;
    logic [egb_pkg::NUM_W-1:0] div_quo;

    logic [5:0]  ch;
    logic [5:0]  n6;
    logic [31:0] age;
    logic        link;
    logic        in_range;
    logic [12:0] mag_c;
    logic [31:0] d_t, d_c;
    logic [31:0] fc_shift;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign ofree     = !out_valid_reg || out_ready;
    assign ch        = item_reg.event_channel;
    assign n6        = n_reg[5:0];
    assign n_hi      = $signed({3'b000, ch}) + $signed({4'b0000, cfg.radius});
    assign in_range  = (n_reg[8:6] == 3'b000);
    assign age       = item_reg.event_time - rt_q;
    assign link      = (item_reg.event_time >= rt_q) && (age > egb_pkg::MIN_AGE)
                       && (age <= cfg.age_limit);
    assign mag_c     = sum_c_reg[12] ? 13'(-sum_c_reg) : sum_c_reg;
    assign d_t       = cfg.feature_mode ? cfg.norm_window : cfg.age_limit;
    assign d_c       = {27'd0, cfg.radius};
    // Global channel scale: mean * 65536 / 64 is an exact shift by 10
    assign fc_shift  = {10'd0, mean_c_reg, 10'd0};

    egb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Walk neighbors, emit records, run the mean and scale divisions
    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        node_cnt_next = node_cnt_reg;
        n_next        = n_reg;
        sum_t_next    = sum_t_reg;
        sum_c_next    = sum_c_reg;
        cnt_next      = cnt_reg;
        mean_t_next   = mean_t_reg;
        mean_c_next   = mean_c_reg;
        neg_c_next    = neg_c_reg;
        ft_next       = ft_reg;
        fc_next       = fc_reg;
        rvalid_next   = rvalid_reg;
        q_pop         = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        load          = 1'b0;
        out_next      = '0;
        div_start     = 1'b0;
        div_num       = '0;
        div_den       = '0;
        unique case (state_reg)
            egb_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_data;
                    sum_t_next = '0;
                    sum_c_next = '0;
                    cnt_next   = '0;
                    ft_next    = '0;
                    fc_next    = '0;
                    state_next = egb_pkg::B_SELF;
                end
            end
            egb_pkg::B_SELF:
            begin
                out_next.node_index     = node_cnt_reg;
                out_next.neighbor_index = node_cnt_reg;
                if (ofree)
                begin
                    load       = 1'b1;
                    n_next     = $signed({3'b000, ch}) - $signed({4'b0000, cfg.radius});
                    state_next = egb_pkg::B_SCAN;
                end
            end
            egb_pkg::B_SCAN:
            begin
                if (n_reg > n_hi)
                begin
                    state_next = (cnt_reg == '0) ? egb_pkg::B_NODE : egb_pkg::B_MT;
                end
                else if (in_range && rvalid_reg[n6])
                begin
                    rd_en      = 1'b1;
                    state_next = egb_pkg::B_CHK;
                end
                else
                begin
                    n_next = n_reg + $signed({3'b000, cfg.stride});
                end
            end
            egb_pkg::B_CHK:
            begin
                out_next.node_index     = node_cnt_reg;
                out_next.neighbor_index = rn_q;
                if (!link)
                begin
                    n_next     = n_reg + $signed({3'b000, cfg.stride});
                    state_next = egb_pkg::B_SCAN;
                end
                else if (ofree)
                begin
                    load     = 1'b1;
                    cnt_next = cnt_reg + 6'd1;
                    if (cfg.feature_mode)
                    begin
                        sum_t_next = sum_t_reg + {6'd0, rt_q};
                        sum_c_next = sum_c_reg + $signed({7'd0, n6});
                    end
                    else
                    begin
                        sum_t_next = sum_t_reg + {6'd0, age};
                        sum_c_next = sum_c_reg + $signed({7'd0, ch}) - $signed({7'd0, n6});
                    end
                    n_next     = n_reg + $signed({3'b000, cfg.stride});
                    state_next = egb_pkg::B_SCAN;
                end
            end
            egb_pkg::B_MT:
            begin
                div_start  = 1'b1;
                div_num    = {12'd0, sum_t_reg} + {45'd0, cnt_reg[5:1]};
                div_den    = {26'd0, cnt_reg};
                state_next = egb_pkg::B_MTW;
            end
            egb_pkg::B_MTW:
            begin
                if (div_done)
                begin
                    mean_t_next = div_quo[32:0];
                    state_next  = egb_pkg::B_MC;
                end
            end
            egb_pkg::B_MC:
            begin
                div_start  = 1'b1;
                div_num    = {37'd0, mag_c} + {45'd0, cnt_reg[5:1]};
                div_den    = {26'd0, cnt_reg};
                neg_c_next = sum_c_reg[12];
                state_next = egb_pkg::B_MCW;
            end
            egb_pkg::B_MCW:
            begin
                if (div_done)
                begin
                    mean_c_next = div_quo[11:0];
                    state_next  = egb_pkg::B_FT;
                end
            end
            egb_pkg::B_FT:
            begin
                if (d_t == '0)
                begin
                    state_next = egb_pkg::B_FC;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = {1'b0, mean_t_reg, 16'd0} + {19'd0, d_t[31:1]};
                    div_den    = d_t;
                    state_next = egb_pkg::B_FTW;
                end
            end
            egb_pkg::B_FTW:
            begin
                if (div_done)
                begin
                    ft_next    = (div_quo > 50'h7FFFFFFF) ? 32'h7FFFFFFF : div_quo[31:0];
                    state_next = egb_pkg::B_FC;
                end
            end
            egb_pkg::B_FC:
            begin
                if (cfg.feature_mode)
                begin
                    fc_next    = neg_c_reg ? 32'(-fc_shift) : fc_shift;
                    state_next = egb_pkg::B_NODE;
                end
                else if (d_c == '0)
                begin
                    state_next = egb_pkg::B_NODE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = {22'd0, mean_c_reg, 16'd0} + {19'd0, d_c[31:1]};
                    div_den    = d_c;
                    state_next = egb_pkg::B_FCW;
                end
            end
            egb_pkg::B_FCW:
            begin
                if (div_done)
                begin
                    if (neg_c_reg)
                    begin
                        fc_next = (div_quo >= 50'h80000000) ? 32'h80000000
                                                            : 32'(-div_quo[31:0]);
                    end
                    else
                    begin
                        fc_next = (div_quo > 50'h7FFFFFFF) ? 32'h7FFFFFFF : div_quo[31:0];
                    end
                    state_next = egb_pkg::B_NODE;
                end
            end
            egb_pkg::B_NODE:
            begin
                out_next.record_kind     = 1'b1;
                out_next.node_index      = node_cnt_reg;
                out_next.node_time       = item_reg.event_time;
                out_next.node_channel    = ch;
                out_next.feature_time    = ft_reg;
                out_next.feature_channel = fc_reg;
                out_next.polarity_out    = cfg.pol_enable & item_reg.event_polarity;
                out_next.last            = 1'b1;
                if (ofree)
                begin
                    load            = 1'b1;
                    wr_en           = 1'b1;
                    rvalid_next[ch] = 1'b1;
                    node_cnt_next   = node_cnt_reg + 32'd1;
                    state_next      = egb_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = egb_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= egb_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            rvalid_reg    <= '0;
            node_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rvalid_reg    <= rvalid_next;
            node_cnt_reg  <= node_cnt_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold working registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        n_reg      <= n_next;
        sum_t_reg  <= sum_t_next;
        sum_c_reg  <= sum_c_next;
        cnt_reg    <= cnt_next;
        mean_t_reg <= mean_t_next;
        mean_c_reg <= mean_c_next;
        neg_c_reg  <= neg_c_next;
        ft_reg     <= ft_next;
        fc_reg     <= fc_next;
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    // Read and update the latest-event tables
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rt_q <= rt_mem[n6];
            rn_q <= rn_mem[n6];
        end
        if (wr_en)
        begin
            rt_mem[ch] <= item_reg.event_time;
            rn_mem[ch] <= node_cnt_reg;
        end
    end

endmodule

// ===== design/event_graph_edge_builder.sv =====
// Event graph edge builder. Each channel event passes a per-channel leaky
// counter in the front end, which takes one event at a time; every third
// close event is queued (four entries) for the back end, which emits a self
// edge, one edge per linked neighbor and a node record with Q15.16 features,
// last set on the node record. The back end reads the tables of each searched
// channel holding an event, skips empty or out-of-range channels and, when
// at least one neighbor linked, runs serial divisions: up to four in local
// feature mode, up to three in global mode where the channel scaling is a
// shift. Configuration must be written by the user only while the block
// is idle, through cfg_we/cfg_index/cfg_data; the block does not enforce it.
module event_graph_edge_builder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  egb_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output egb_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [4:0]        radius_reg;
    logic [5:0]        skip_reg;
    logic [31:0]       tradius_reg;
    logic [31:0]       twindow_reg;
    logic              mode_reg;
    logic              pol_reg;
    egb_pkg::cfg_t     cfg;
    logic              q_full, q_empty, q_push, q_pop;
    egb_pkg::in_item_t q_wdata, q_rdata;

    // Clamp radius and stride
    always_comb
    begin
        cfg.radius       = (radius_reg > 5'(egb_pkg::MAX_RADIUS)) ? 5'(egb_pkg::MAX_RADIUS)
                                                                 : radius_reg;
        cfg.stride       = (skip_reg == '0) ? 6'd1 : skip_reg;
        cfg.age_limit    = tradius_reg;
        cfg.norm_window  = twindow_reg;
        cfg.feature_mode = mode_reg;
        cfg.pol_enable   = pol_reg;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= 5'd3;
            skip_reg    <= 6'd1;
            tradius_reg <= 32'd50000;
            twindow_reg <= 32'd1000000;
            mode_reg    <= 1'b0;
            pol_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                egb_pkg::REG_CHANNEL_RADIUS: radius_reg  <= cfg_data[4:0];
                egb_pkg::REG_SKIP_CHANNELS:  skip_reg    <= cfg_data[5:0];
                egb_pkg::REG_AGE_LIMIT:      tradius_reg <= cfg_data;
                egb_pkg::REG_NORM_WINDOW:    twindow_reg <= cfg_data;
                egb_pkg::REG_FEATURE_MODE:   mode_reg    <= cfg_data[0];
                egb_pkg::REG_POL_ENABLE:     pol_reg     <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    egb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    egb_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    egb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== design/egb_chk.sv =====
`include "assert_macros.svh"

module egb_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input egb_pkg::out_item_t out_data
);

    logic edge_rec;
    logic edge_bare;

    assign edge_rec  = out_valid && !out_data.record_kind;
    assign edge_bare = (out_data.node_time == '0) && (out_data.node_channel == '0)
                       && (out_data.feature_time == '0) && (out_data.feature_channel == '0)
                       && (out_data.polarity_out == 1'b0);

    // Hold a stalled record
    `EGB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // Close each event with a node record and only with it
    `EGB_ASSERT_IMP(a_last_kind, out_valid, out_data.last == out_data.record_kind)

    // Keep node fields clear in edge records
    `EGB_ASSERT_IMP(a_edge_clean, edge_rec, edge_bare)

    // Keep neighbor field clear in node records
    `EGB_ASSERT_IMP(a_node_clean, out_valid && out_data.record_kind, out_data.neighbor_index == '0)

endmodule

bind event_graph_edge_builder egb_chk u_chk (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    egb_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    egb_pkg::out_item_t out_data;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    event_graph_edge_builder uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    typedef struct {
        egb_pkg::in_item_t ev;
        int                ntyped;
    } dir_row_t;

    // shadow configuration
    logic [4:0]  m_radius;
    logic [5:0]  m_stride;
    logic [31:0] m_age_limit;
    logic [31:0] m_norm_window;
    logic        m_feature_mode;
    logic        m_pol_enable;

    // shadow channel state
    logic [31:0] leak_time [egb_pkg::CHANNEL_COUNT];
    logic [1:0]  leak_level [egb_pkg::CHANNEL_COUNT];
    logic [31:0] seen_time [egb_pkg::CHANNEL_COUNT];
    logic [31:0] last_node [egb_pkg::CHANNEL_COUNT];
    logic        last_seen [egb_pkg::CHANNEL_COUNT];
    logic [31:0] next_node;

    egb_pkg::out_item_t records_due[$];
    egb_pkg::out_item_t typed_records[$];
    dir_row_t           dir_rows[$];
    bit                 use_typed;
    int                 fails;
    int                 idle_pct;
    int                 stall_pct;
    int                 hold_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // drive every input to a known value from the start
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = egb_pkg::REG_CHANNEL_RADIUS;
        cfg_data  = '0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 0;
        use_typed = 1'b0;
        fails     = 0;
    end

    function automatic egb_pkg::out_item_t make_record(logic kind, logic [31:0] src,
                                                       logic [31:0] dst, logic [31:0] t,
                                                       logic [5:0] ch, logic [31:0] ft,
                                                       logic [31:0] fc, logic pol,
                                                       logic lst);
        egb_pkg::out_item_t r;
        r.record_kind     = kind;
        r.node_index      = src;
        r.neighbor_index  = dst;
        r.node_time       = t;
        r.node_channel    = ch;
        r.feature_time    = ft;
        r.feature_channel = fc;
        r.polarity_out    = pol;
        r.last            = lst;
        return r;
    endfunction

    // signed mean scaled to Q15.16 by a divisor, rounded and saturated
    function automatic logic [31:0] scale_q16(longint mean, logic [63:0] d);
        logic [63:0] mag;
        logic [63:0] v;
        if (d == 0)
            return 32'd0;
        mag = (mean < 0) ? -mean : mean;
        v = ((mag << 16) + d / 2) / d;
        if (mean < 0)
            return (v >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-v);
        return (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
    endfunction

    // leaky filter, neighbor search and node features for one event
    task automatic build_edges(egb_pkg::in_item_t e, ref egb_pkg::out_item_t res[$]);
        logic [31:0] t;
        int          ch;
        logic [31:0] dt;
        logic [31:0] decay;
        logic [31:0] lvl;
        logic [31:0] idx;
        logic [31:0] age;
        int          rad;
        int          step;
        logic [63:0] sum_t;
        longint      sum_c;
        logic [63:0] cnt;
        logic [63:0] mean_t;
        longint      mean_c;
        logic [63:0] cm;
        logic [31:0] ft;
        logic [31:0] fc;
        t  = e.event_time;
        ch = e.event_channel;
        dt = (t >= leak_time[ch]) ? t - leak_time[ch] : 32'd0;
        decay = dt / (32'd1000 + 32'd100 * ch);
        lvl = leak_level[ch];
        lvl = (decay >= lvl) ? 32'd0 : lvl - decay;
        lvl = lvl + 1;
        leak_time[ch] = t;
        if (lvl < 3)
        begin
            leak_level[ch] = lvl[1:0];
            return;
        end
        leak_level[ch] = 2'd0;
        idx = next_node;
        res = {res, make_record(1'b0, idx, idx, 0, 0, 0, 0, 1'b0, 1'b0)};
        rad   = (m_radius > egb_pkg::MAX_RADIUS) ? egb_pkg::MAX_RADIUS : m_radius;
        step  = (m_stride != 0) ? m_stride : 1;
        sum_t = 0;
        sum_c = 0;
        cnt   = 0;
        for (int n = ch - rad; n <= ch + rad; n += step)
        begin
            if (n < 0 || n >= egb_pkg::CHANNEL_COUNT || !last_seen[n] || t < seen_time[n])
                continue;
            age = t - seen_time[n];
            if (age > 32'd2000 && age <= m_age_limit)
            begin
                res = {res, make_record(1'b0, idx, last_node[n], 0, 0, 0, 0,
                                        1'b0, 1'b0)};
                if (!m_feature_mode)
                begin
                    sum_t += age;
                    sum_c += ch - n;
                end
                else
                begin
                    sum_t += seen_time[n];
                    sum_c += n;
                end
                cnt++;
            end
        end
        mean_t = 0;
        mean_c = 0;
        if (cnt != 0)
        begin
            cm = (sum_c < 0) ? -sum_c : sum_c;
            mean_t = (sum_t + cnt / 2) / cnt;
            mean_c = (cm + cnt / 2) / cnt;
            if (sum_c < 0)
                mean_c = -mean_c;
        end
        if (!m_feature_mode)
        begin
            ft = scale_q16(mean_t, m_age_limit);
            fc = scale_q16(mean_c, rad);
        end
        else
        begin
            ft = scale_q16(mean_t, m_norm_window);
            fc = scale_q16(mean_c, egb_pkg::CHANNEL_COUNT);
        end
        seen_time[ch] = t;
        last_node[ch] = idx;
        last_seen[ch] = 1'b1;
        next_node     = idx + 1;
        res = {res, make_record(1'b1, idx, 0, t, ch[5:0], ft, fc,
                                m_pol_enable & e.event_polarity, 1'b1)};
    endtask

    // predict on each accepted item, check each accepted result
    always @(posedge clk)
    begin
        egb_pkg::out_item_t fresh[$];
        egb_pkg::out_item_t want;
        if (rst_n && in_valid && in_ready)
        begin
            fresh.delete();
            build_edges(in_data, fresh);
            if (!use_typed)
                records_due = {records_due, fresh};
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (records_due.size() == 0)
            begin
                $display("%0t: unexpected record, expected none, got %p", $time, out_data);
                fails++;
            end
            else
            begin
                want = records_due.pop_front();
                if (out_data !== want)
                begin
                    $display("%0t: record mismatch, expected %p, got %p",
                             $time, want, out_data);
                    fails++;
                end
            end
        end
    end

    // receiver: random stall plus an optional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else
            out_ready = ($urandom_range(99) >= stall_pct);
    end

    task automatic send_event(logic [31:0] t, logic [5:0] ch, logic pol);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_data  = '{event_time: t, event_channel: ch, event_polarity: pol};
        in_valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        @(negedge clk);
    endtask

    task automatic write_reg(egb_pkg::reg_idx_t idx, logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        case (idx)
            egb_pkg::REG_CHANNEL_RADIUS: m_radius       = val[4:0];
            egb_pkg::REG_SKIP_CHANNELS:  m_stride       = val[5:0];
            egb_pkg::REG_AGE_LIMIT:      m_age_limit    = val;
            egb_pkg::REG_NORM_WINDOW:    m_norm_window  = val;
            egb_pkg::REG_FEATURE_MODE:   m_feature_mode = val[0];
            egb_pkg::REG_POL_ENABLE:     m_pol_enable   = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // hold until every record is out, then let dropped items settle
    task automatic drain();
        in_valid = 1'b0;
        while (records_due.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic add_row(logic [31:0] t, logic [5:0] ch, logic pol, int ntyped);
        dir_row_t r;
        r.ev     = '{event_time: t, event_channel: ch, event_polarity: pol};
        r.ntyped = ntyped;
        dir_rows = {dir_rows, r};
    endtask

    initial
    begin
        dir_row_t    r;
        logic [31:0] now;
        logic [5:0]  ch;
        int          sent;
        int          pick;
        for (int i = 0; i < egb_pkg::CHANNEL_COUNT; i++)
        begin
            leak_time[i]  = 0;
            leak_level[i] = 0;
            seen_time[i]  = 0;
            last_node[i]  = 0;
            last_seen[i]  = 1'b0;
        end
        next_node      = 0;
        m_radius       = 5'd3;
        m_stride       = 6'd1;
        m_age_limit    = 32'd50000;
        m_norm_window  = 32'd1000000;
        m_feature_mode = 1'b0;
        m_pol_enable   = 1'b0;

        // directed items; the first two kept events are known by hand
        add_row(0, 0, 0, 0);
        add_row(0, 0, 0, 0);
        add_row(0, 0, 1, 2);
        typed_records = {typed_records, make_record(0, 0, 0, 0, 0, 0, 0, 0, 0)};
        typed_records = {typed_records, make_record(1, 0, 0, 0, 0, 0, 0, 0, 1)};
        add_row(5000, 1, 0, 0);
        add_row(5000, 1, 0, 0);
        add_row(5000, 1, 1, 3);
        typed_records = {typed_records, make_record(0, 1, 1, 0, 0, 0, 0, 0, 0)};
        typed_records = {typed_records, make_record(0, 1, 0, 0, 0, 0, 0, 0, 0)};
        typed_records = {typed_records, make_record(1, 1, 0, 5000, 1, 32'd6554,
                                                    32'd21845, 0, 1)};
        for (int i = 0; i < 3; i++) add_row(10000, 63, 1, 0);
        for (int i = 0; i < 3; i++) add_row(10500, 62, 0, 0);
        // earlier timestamp: channel 1 lies later and must not link
        for (int i = 0; i < 3; i++) add_row(3000, 2, 1, 0);
        for (int i = 0; i < 3; i++) add_row(32'hFFFF_FFFF, 63, 1, 0);
        for (int i = 0; i < 3; i++) add_row(32'hFFFF_FFFE, 62, 0, 0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            for (int k = 0; k < r.ntyped; k++)
                records_due = {records_due, typed_records.pop_front()};
            use_typed = (r.ntyped > 0);
            send_event(r.ev.event_time, r.ev.event_channel, r.ev.event_polarity);
            use_typed = 1'b0;
        end
        drain();

        now = 0;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                1:
                begin
                    write_reg(egb_pkg::REG_CHANNEL_RADIUS, 30);
                    write_reg(egb_pkg::REG_SKIP_CHANNELS, 1);
                    write_reg(egb_pkg::REG_AGE_LIMIT, 32'hFFFF_FFFF);
                    write_reg(egb_pkg::REG_NORM_WINDOW, 1);
                    write_reg(egb_pkg::REG_FEATURE_MODE, 1);
                    write_reg(egb_pkg::REG_POL_ENABLE, 1);
                end
                2:
                begin
                    write_reg(egb_pkg::REG_CHANNEL_RADIUS, 0);
                    write_reg(egb_pkg::REG_SKIP_CHANNELS, 61);
                    write_reg(egb_pkg::REG_AGE_LIMIT, 0);
                    write_reg(egb_pkg::REG_FEATURE_MODE, 0);
                end
                3:
                begin
                    write_reg(egb_pkg::REG_CHANNEL_RADIUS, 31);
                    write_reg(egb_pkg::REG_SKIP_CHANNELS, 0);
                    write_reg(egb_pkg::REG_AGE_LIMIT, 100000);
                    write_reg(egb_pkg::REG_NORM_WINDOW, 32'hFFFF_FFFF);
                    write_reg(egb_pkg::REG_POL_ENABLE, 0);
                end
                4:
                begin
                    write_reg(egb_pkg::REG_CHANNEL_RADIUS, 5);
                    write_reg(egb_pkg::REG_SKIP_CHANNELS, 2);
                    write_reg(egb_pkg::REG_AGE_LIMIT, 20000);
                    write_reg(egb_pkg::REG_NORM_WINDOW, 1000000);
                    write_reg(egb_pkg::REG_FEATURE_MODE, 1);
                    write_reg(egb_pkg::REG_POL_ENABLE, 1);
                    // long receiver hold-off while items keep coming
                    hold_left = 600;
                end
                5:
                begin
                    write_reg(egb_pkg::REG_CHANNEL_RADIUS, $urandom_range(31));
                    write_reg(egb_pkg::REG_SKIP_CHANNELS, $urandom_range(63));
                    write_reg(egb_pkg::REG_AGE_LIMIT, $urandom_range(200000, 2000));
                    write_reg(egb_pkg::REG_NORM_WINDOW, $urandom);
                    write_reg(egb_pkg::REG_FEATURE_MODE, $urandom_range(1));
                    write_reg(egb_pkg::REG_POL_ENABLE, $urandom_range(1));
                end
                default: ;
            endcase
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase

            // mostly close triples that pass the filter, some noise
            sent = 0;
            while (sent < 72)
            begin
                pick = $urandom_range(99);
                ch   = 6'($urandom_range(63));
                if (pick < 75)
                begin
                    now += $urandom_range(12000);
                    for (int k = 0; k < 3; k++)
                        send_event(now + $urandom_range(200) * k, ch,
                                   1'($urandom_range(1)));
                    now += 400;
                    sent += 3;
                end
                else if (pick < 85)
                begin
                    send_event(now, ch, 1'($urandom_range(1)));
                    sent++;
                end
                else if (pick < 93)
                begin
                    send_event(now - $urandom_range(5000), ch, 1'($urandom_range(1)));
                    sent++;
                end
                else
                begin
                    now = $urandom;
                    send_event(now, ch, 1'($urandom_range(1)));
                    sent++;
                end
            end
            drain();
        end

        if (fails == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // stop a hung run
    initial
    begin
        #30_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
